### rtl/rbfr_pkg.sv
// Shared constants, types and ring arithmetic for the ring buffered frame receiver.
// Depends on nothing; imported by ring_buffered_frame_receiver.
package rbfr_pkg;

	localparam int RING_DEPTH      = 512;
	localparam int MIN_FRAME_BYTES = 7;
	localparam int FRAME_OVERHEAD  = 7;
	localparam int COPY_LIMIT      = 64;

	localparam int AW = $clog2(RING_DEPTH);
	localparam int LW = ((AW > 8) ? AW : 8) + 1;

	localparam logic [AW:0]  DEPTH_W  = (AW + 1)'(RING_DEPTH);
	localparam logic [15:0]  CRC_INIT = 16'hFFFF;
	localparam logic [15:0]  CRC_POLY = 16'hA001;

	typedef logic [AW-1:0] ring_ptr_t;

	typedef enum logic [1:0] {
		KIND_WRITE_OK  = 2'd0,
		KIND_OVERFLOW  = 2'd1,
		KIND_NO_FRAME  = 2'd2,
		KIND_FRAME     = 2'd3
	} result_kind_t;

	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_POLL  = 1'b1
	} req_type_t;

	typedef enum logic [1:0] {
		CFG_HEAD_FIRST  = 2'd0,
		CFG_HEAD_SECOND = 2'd1,
		CFG_MAX_COPY    = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_index_t;

	// Add two ring offsets modulo the ring depth.
	function automatic ring_ptr_t ring_add(input ring_ptr_t a, input ring_ptr_t b);
		logic [AW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// Number of stored bytes between read and write positions.
	function automatic ring_ptr_t ring_fill(input ring_ptr_t wp, input ring_ptr_t rp);
		logic [AW:0] s;
		s = {1'b0, wp} + DEPTH_W - {1'b0, rp};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	// One bit step of the reflected CRC-16.
	function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
		return crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
	endfunction

endpackage

### rtl/ring_buffered_frame_receiver.sv
// Top level of the ring buffered frame receiver: byte ring, frame search sequencer,
// bitwise CRC-16 unit and stream ports. Depends on rbfr_pkg.

// Stream deframer. Each slave transaction either stores one received byte
// (tuser 0) or polls for a frame (tuser 1). A frame is: first sync byte,
// second sync byte, length byte LEN, LEN payload bytes, CRC-16/Modbus over
// LEN and payload (low byte first), two tail bytes that are never checked.
// The ring holds RING_DEPTH-1 bytes; a write to a full ring drops the byte,
// empties the ring and answers overflow. A write answers in the cycle after
// acceptance. A poll is run by one sequencer over a single memory read port
// and a one-bit-per-cycle CRC unit: each byte read puts the address on the
// port in ST_WAIT and then uses the registered data, the header scan reads
// one byte per position, and every CRC byte is read and then shifted in bit
// by bit. Each further payload byte is read only after the result before it
// has been taken, and each CRC mismatch restarts the scan one byte past the
// rejected header. The slave side is not ready from acceptance until the
// last result of that transaction has been taken. Configuration writes
// are taken in any cycle and are expected only while the block is idle.
module ring_buffered_frame_receiver
	import rbfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic        s_tuser,   // [0] req_type

	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [15:8] payload_length
	output logic [2:0]  m_tuser,   // [1:0] result_kind, [2] byte_valid
	output logic        m_tlast,   // last_result

	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POLL_START,
		ST_WAIT,
		ST_SCAN_DATA,
		ST_LEN_DATA,
		ST_CRC_DATA,
		ST_CRC_BIT,
		ST_RXLO_DATA,
		ST_RXHI_DATA,
		ST_PAY_DATA,
		ST_OUT
	} state_t;

	// Configuration registers
	logic [7:0] head_first_q;
	logic [7:0] head_second_q;
	logic [6:0] max_copy_q;

	// Ring storage and pointers
	logic [7:0] ring_mem [RING_DEPTH];
	logic [7:0] rd_data_q;
	ring_ptr_t  write_pos_q;
	ring_ptr_t  read_pos_q;
	ring_ptr_t  rd_off_q;
	ring_ptr_t  rd_addr;
	ring_ptr_t  fill;

	// Sequencer
	state_t       state_q;
	state_t       wait_ret_q;
	ring_ptr_t    n_q;
	ring_ptr_t    off_q;
	ring_ptr_t    hdr_q;
	logic         prev_match_q;
	logic [7:0]   len_q;
	logic [15:0]  crc_q;
	logic [2:0]   bit_q;
	logic [7:0]   crc_left_q;
	logic [7:0]   rx_lo_q;
	logic [6:0]   cp_left_q;
	ring_ptr_t    rp_next_q;
	logic         commit_q;

	// Registered result
	logic         out_valid_q;
	result_kind_t kind_q;
	logic [7:0]   pbyte_q;
	logic         bvalid_q;
	logic [7:0]   plen_q;
	logic         last_q;

	// Decode helpers
	ring_ptr_t    hdr_cand;
	ring_ptr_t    avail_cand;
	ring_ptr_t    avail;
	logic [LW-1:0] need;
	logic [6:0]   copy_lim;
	logic [6:0]   copy_cnt;
	logic [LW-1:0] frame_end;

	assign rd_addr    = ring_add(read_pos_q, rd_off_q);
	assign fill       = ring_fill(write_pos_q, read_pos_q);
	assign hdr_cand   = off_q - ring_ptr_t'(1);
	assign avail_cand = n_q - hdr_cand;
	assign avail      = n_q - hdr_q;
	assign need       = LW'(rd_data_q) + LW'(FRAME_OVERHEAD);
	assign copy_lim   = (max_copy_q > 7'(COPY_LIMIT)) ? 7'(COPY_LIMIT) : max_copy_q;
	assign copy_cnt   = ({1'b0, len_q[6:0]} < {1'b0, copy_lim} && len_q[7] == 1'b0) ?
		len_q[6:0] : copy_lim;
	assign frame_end  = LW'(hdr_q) + LW'(len_q) + LW'(FRAME_OVERHEAD);

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {plen_q, pbyte_q};
	assign m_tuser   = {bvalid_q, kind_q};
	assign m_tlast   = last_q;

	// Configuration registers: index beyond the list is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_first_q  <= 8'd170;
			head_second_q <= 8'd85;
			max_copy_q    <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_HEAD_FIRST:  head_first_q  <= cfg_data;
				CFG_HEAD_SECOND: head_second_q <= cfg_data;
				CFG_MAX_COPY:    max_copy_q    <= cfg_data[6:0];
				CFG_UNUSED:      ;
				default:         ;
			endcase
		end
	end

	// Ring memory: one write port for stored bytes, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid && req_type_t'(s_tuser) == REQ_WRITE &&
		    fill != ring_ptr_t'(RING_DEPTH - 1)) begin
			ring_mem[write_pos_q] <= s_tdata;
		end
		rd_data_q <= ring_mem[rd_addr];
	end

	// Sequencer with registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wait_ret_q   <= ST_IDLE;
			write_pos_q  <= '0;
			read_pos_q   <= '0;
			rd_off_q     <= '0;
			n_q          <= '0;
			off_q        <= '0;
			hdr_q        <= '0;
			prev_match_q <= 1'b0;
			len_q        <= '0;
			crc_q        <= CRC_INIT;
			bit_q        <= '0;
			crc_left_q   <= '0;
			rx_lo_q      <= '0;
			cp_left_q    <= '0;
			rp_next_q    <= '0;
			commit_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_WRITE_OK;
			pbyte_q      <= '0;
			bvalid_q     <= 1'b0;
			plen_q       <= '0;
			last_q       <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						if (req_type_t'(s_tuser) == REQ_POLL) begin
							state_q <= ST_POLL_START;
						end else begin
							// Full ring: drop the byte and empty the ring.
							if (fill == ring_ptr_t'(RING_DEPTH - 1)) begin
								read_pos_q <= write_pos_q;
								kind_q     <= KIND_OVERFLOW;
							end else begin
								write_pos_q <= ring_add(write_pos_q, ring_ptr_t'(1));
								kind_q      <= KIND_WRITE_OK;
							end
							pbyte_q     <= '0;
							bvalid_q    <= 1'b0;
							plen_q      <= '0;
							last_q      <= 1'b1;
							commit_q    <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end
					end
				end

				ST_POLL_START: begin
					if (LW'(fill) < LW'(MIN_FRAME_BYTES)) begin
						kind_q      <= KIND_NO_FRAME;
						pbyte_q     <= '0;
						bvalid_q    <= 1'b0;
						plen_q      <= '0;
						last_q      <= 1'b1;
						commit_q    <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						n_q          <= fill;
						off_q        <= '0;
						rd_off_q     <= '0;
						prev_match_q <= 1'b0;
						wait_ret_q   <= ST_SCAN_DATA;
						state_q      <= ST_WAIT;
					end
				end

				// Address is on the read port; data lands in rd_data_q.
				ST_WAIT: begin
					state_q <= wait_ret_q;
				end

				ST_SCAN_DATA: begin
					if (prev_match_q && rd_data_q == head_second_q) begin
						hdr_q <= hdr_cand;
						if (LW'(avail_cand) < LW'(FRAME_OVERHEAD)) begin
							// Header found but frame cannot be complete yet.
							kind_q      <= KIND_NO_FRAME;
							pbyte_q     <= '0;
							bvalid_q    <= 1'b0;
							plen_q      <= '0;
							last_q      <= 1'b1;
							commit_q    <= 1'b0;
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							rd_off_q   <= off_q + ring_ptr_t'(1);
							wait_ret_q <= ST_LEN_DATA;
							state_q    <= ST_WAIT;
						end
					end else if (off_q == n_q - ring_ptr_t'(1)) begin
						// No header anywhere: advance one byte.
						read_pos_q  <= ring_add(read_pos_q, ring_ptr_t'(1));
						kind_q      <= KIND_NO_FRAME;
						pbyte_q     <= '0;
						bvalid_q    <= 1'b0;
						plen_q      <= '0;
						last_q      <= 1'b1;
						commit_q    <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						prev_match_q <= (rd_data_q == head_first_q);
						off_q        <= off_q + ring_ptr_t'(1);
						rd_off_q     <= off_q + ring_ptr_t'(1);
						wait_ret_q   <= ST_SCAN_DATA;
						state_q      <= ST_WAIT;
					end
				end

				ST_LEN_DATA: begin
					len_q <= rd_data_q;
					if (LW'(avail) < need) begin
						kind_q      <= KIND_NO_FRAME;
						pbyte_q     <= '0;
						bvalid_q    <= 1'b0;
						plen_q      <= '0;
						last_q      <= 1'b1;
						commit_q    <= 1'b0;
						out_valid_q <= 1'b1;
						state_q     <= ST_OUT;
					end else begin
						// Length byte is the first CRC byte.
						crc_q      <= CRC_INIT ^ {8'h00, rd_data_q};
						crc_left_q <= rd_data_q;
						bit_q      <= '0;
						state_q    <= ST_CRC_BIT;
					end
				end

				ST_CRC_DATA: begin
					crc_q   <= crc_q ^ {8'h00, rd_data_q};
					bit_q   <= '0;
					state_q <= ST_CRC_BIT;
				end

				ST_CRC_BIT: begin
					crc_q <= crc_bit_step(crc_q);
					bit_q <= bit_q + 3'd1;
					if (bit_q == 3'd7) begin
						rd_off_q <= rd_off_q + ring_ptr_t'(1);
						if (crc_left_q == 8'd0) begin
							wait_ret_q <= ST_RXLO_DATA;
						end else begin
							crc_left_q <= crc_left_q - 8'd1;
							wait_ret_q <= ST_CRC_DATA;
						end
						state_q <= ST_WAIT;
					end
				end

				ST_RXLO_DATA: begin
					rx_lo_q    <= rd_data_q;
					rd_off_q   <= rd_off_q + ring_ptr_t'(1);
					wait_ret_q <= ST_RXHI_DATA;
					state_q    <= ST_WAIT;
				end

				ST_RXHI_DATA: begin
					if ({rd_data_q, rx_lo_q} != crc_q) begin
						// Reject this header and search again one byte past it.
						read_pos_q <= ring_add(read_pos_q, hdr_q + ring_ptr_t'(1));
						state_q    <= ST_POLL_START;
					end else begin
						rp_next_q <= ring_add(read_pos_q, frame_end[AW-1:0]);
						if (copy_cnt == 7'd0) begin
							kind_q      <= KIND_FRAME;
							pbyte_q     <= '0;
							bvalid_q    <= 1'b0;
							plen_q      <= len_q;
							last_q      <= 1'b1;
							commit_q    <= 1'b1;
							out_valid_q <= 1'b1;
							state_q     <= ST_OUT;
						end else begin
							cp_left_q  <= copy_cnt;
							rd_off_q   <= hdr_q + ring_ptr_t'(3);
							wait_ret_q <= ST_PAY_DATA;
							state_q    <= ST_WAIT;
						end
					end
				end

				ST_PAY_DATA: begin
					kind_q      <= KIND_FRAME;
					pbyte_q     <= rd_data_q;
					bvalid_q    <= 1'b1;
					plen_q      <= len_q;
					last_q      <= (cp_left_q == 7'd1);
					commit_q    <= (cp_left_q == 7'd1);
					cp_left_q   <= cp_left_q - 7'd1;
					rd_off_q    <= rd_off_q + ring_ptr_t'(1);
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end

				ST_OUT: begin
					if (m_tready) begin
						out_valid_q <= 1'b0;
						if (last_q) begin
							// Consume the whole frame once its last result is taken.
							if (commit_q) begin
								read_pos_q <= rp_next_q;
							end
							state_q <= ST_IDLE;
						end else begin
							wait_ret_q <= ST_PAY_DATA;
							state_q    <= ST_WAIT;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Input is never taken while a result is pending.
	a_no_accept_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !m_tvalid)
		else $error("slave ready while a result is pending");

	// A payload byte only comes with a found frame.
	a_byte_only_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == KIND_FRAME))
		else $error("payload byte flagged outside a found frame");

	// The ring never reports more than depth minus one stored bytes.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		LW'(fill) < LW'(RING_DEPTH))
		else $error("ring fill out of range");

	// A CRC byte always runs its shift steps back to back.
	a_crc_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CRC_BIT && bit_q != 3'd7) |=> (state_q == ST_CRC_BIT))
		else $error("CRC shift sequence broken");

endmodule
